### rtl/planar_span_clip_fill_core_macros.svh
// Assertion macros for the planar span fill core.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef PLANAR_SPAN_CLIP_FILL_CORE_MACROS_SVH
`define PLANAR_SPAN_CLIP_FILL_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSCF_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pscf assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PSCF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pscf assertion failed");

`endif

### rtl/pscf_pkg.sv
// Shared types and constants of the planar span fill core.
// No dependencies; used by every module of the block.
package pscf_pkg;

	localparam int ROW_BYTES = 80;
	localparam int PLANES    = 4;
	localparam int MAX_RUNS  = 4;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_BAND_TOP     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BAND_BOTTOM  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEFT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COL_LIMIT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_REMAP_ENABLE = 3'd5;

	typedef struct packed {
		logic [15:0] band_top;
		logic [15:0] band_bottom;
		logic [15:0] clip_left;
		logic [15:0] col_limit;
		logic [15:0] frame_base;
		logic        remap_enable;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  color;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] width;
	} span_req_t;

	typedef struct packed {
		logic [15:0] address;
		logic [14:0] byte_count;
		logic [3:0]  plane_mask;
	} run_t;

	typedef struct packed {
		run_t [MAX_RUNS-1:0] runs;
		logic [2:0]          count;
		logic                remap_op;
		logic [7:0]          fill_color;
	} run_set_t;

	typedef struct packed {
		logic can_load;
	} queue_status_t;

endpackage

### rtl/pscf_cfg_regs.sv
// Configuration register file of the planar span fill core.
// Depends on pscf_pkg for the register indexes and cfg_t.
module pscf_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [pscf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pscf_pkg::CFG_DATA_W-1:0]      cfg_data,
	output pscf_pkg::cfg_t                       cfg
);

	pscf_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.band_top     <= 16'd0;
			cfg_q.band_bottom  <= 16'd200;
			cfg_q.clip_left    <= 16'd0;
			cfg_q.col_limit    <= 16'd320;
			cfg_q.frame_base   <= 16'd0;
			cfg_q.remap_enable <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				pscf_pkg::CFG_BAND_TOP:     cfg_q.band_top     <= cfg_data;
				pscf_pkg::CFG_BAND_BOTTOM:  cfg_q.band_bottom  <= cfg_data;
				pscf_pkg::CFG_CLIP_LEFT:    cfg_q.clip_left    <= cfg_data;
				pscf_pkg::CFG_COL_LIMIT:    cfg_q.col_limit    <= cfg_data;
				pscf_pkg::CFG_FRAME_BASE:   cfg_q.frame_base   <= cfg_data;
				pscf_pkg::CFG_REMAP_ENABLE: cfg_q.remap_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/pscf_span_calc.sv
// Combinational span clipping and run generation for one span request.
// Depends on pscf_pkg for span_req_t, cfg_t and run_set_t.
module pscf_span_calc (
	input  pscf_pkg::span_req_t req,
	input  pscf_pkg::cfg_t      cfg,
	output pscf_pkg::run_set_t  result
);

	logic        reject;
	logic [15:0] dl;
	logic [15:0] amount;
	logic [15:0] cw1;
	logic [15:0] x1;
	logic        rej_left;
	logic [15:0] x_end;
	logic [15:0] dr;
	logic [15:0] cw2;
	logic        rej_right;
	logic [15:0] row_off;
	logic [15:0] addr;
	logic [1:0]  sp;

	always_comb begin
		reject = ($signed(req.width) <= $signed(16'd0))
			|| ($signed(req.y) < $signed(cfg.band_top))
			|| ($signed(req.y) >= $signed(cfg.band_bottom));

		dl     = req.x - cfg.clip_left;
		amount = 16'd0 - dl;
		if (dl[15]) begin
			cw1      = req.width - amount;
			rej_left = $signed(req.width) <= $signed(amount);
			x1       = cfg.clip_left;
		end else begin
			cw1      = req.width;
			rej_left = 1'b0;
			x1       = req.x;
		end

		x_end = x1 + cw1;
		dr    = x_end - cfg.col_limit;
		if ($signed(x_end) >= $signed(cfg.col_limit)) begin
			cw2       = cw1 - dr;
			rej_right = $signed(cw1) <= $signed(dr);
		end else begin
			cw2       = cw1;
			rej_right = 1'b0;
		end

		row_off = req.y * 16'(pscf_pkg::ROW_BYTES);
		addr    = cfg.frame_base + row_off + {2'b00, x1[15:2]};
		sp      = x1[1:0];
	end

	always_comb begin
		logic [2:0]  n;
		logic [2:0]  pl;
		logic [2:0]  pc;
		logic [15:0] a;
		logic [15:0] cw3;
		logic [13:0] mid;
		logic [1:0]  part;
		logic        done;

		result            = '0;
		result.remap_op   = cfg.remap_enable;
		result.fill_color = cfg.remap_enable ? 8'd0 : req.color;
		n    = 3'd0;
		pl   = 3'd0;
		pc   = 3'd0;
		a    = addr;
		cw3  = cw2;
		mid  = cw2[15:2];
		part = cw2[1:0];
		done = 1'b0;

		if (reject || rej_left || rej_right) begin
			n = 3'd0;
		end else if (cfg.remap_enable) begin
			for (int p = 0; p < pscf_pkg::MAX_RUNS; p++) begin
				pl = {1'b0, sp} + 3'(p);
				result.runs[p].address    = addr + {15'd0, pl[2]};
				result.runs[p].byte_count = {1'b0, mid} + {14'd0, (2'(p) < part)};
				result.runs[p].plane_mask = 4'b0001 << pl[1:0];
			end
			n = 3'd4;
		end else begin
			if (sp != 2'd0) begin
				pc = 3'd4 - {1'b0, sp};
				if (cw2 < {13'd0, pc}) begin
					result.runs[0].address    = addr;
					result.runs[0].byte_count = 15'd1;
					result.runs[0].plane_mask = ((4'b0001 << cw2[1:0]) - 4'b0001) << sp;
					n    = 3'd1;
					done = 1'b1;
				end else begin
					result.runs[0].address    = addr;
					result.runs[0].byte_count = 15'd1;
					result.runs[0].plane_mask = 4'hf << sp;
					n   = 3'd1;
					a   = addr + 16'd1;
					cw3 = cw2 - {13'd0, pc};
				end
			end
			if (!done) begin
				mid  = cw3[15:2];
				part = cw3[1:0];
				if (mid != 14'd0) begin
					result.runs[n[1:0]].address    = a;
					result.runs[n[1:0]].byte_count = {1'b0, mid};
					result.runs[n[1:0]].plane_mask = 4'hf;
					n = n + 3'd1;
					a = a + {2'b00, mid};
				end
				if (part != 2'd0) begin
					result.runs[n[1:0]].address    = a;
					result.runs[n[1:0]].byte_count = 15'd1;
					result.runs[n[1:0]].plane_mask = (4'b0001 << part) - 4'b0001;
					n = n + 3'd1;
				end
			end
		end
		result.count = n;
	end

endmodule

### rtl/pscf_run_queue.sv
// Result register stage that holds the runs of one span and sends one per cycle.
// Depends on pscf_pkg for run_set_t, run_t and queue_status_t.
module pscf_run_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  pscf_pkg::run_set_t      runs_in,
	output pscf_pkg::queue_status_t status,
	output logic                    strobe,
	output pscf_pkg::run_t          run,
	output logic                    remap_op,
	output logic [7:0]              fill_color,
	output logic                    last
);

	pscf_pkg::run_t [pscf_pkg::MAX_RUNS-1:0] runs_s2;
	logic [2:0] rem_s2;
	logic       op_s2;
	logic [7:0] color_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_s2 <= 3'd0;
		end else if (load) begin
			rem_s2 <= runs_in.count;
		end else if (rem_s2 != 3'd0) begin
			rem_s2 <= rem_s2 - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			runs_s2  <= runs_in.runs;
			op_s2    <= runs_in.remap_op;
			color_s2 <= runs_in.fill_color;
		end else if (rem_s2 != 3'd0) begin
			for (int i = 0; i < pscf_pkg::MAX_RUNS - 1; i++) begin
				runs_s2[i] <= runs_s2[i+1];
			end
		end
	end

	assign status.can_load = (rem_s2 <= 3'd1);
	assign strobe          = (rem_s2 != 3'd0);
	assign run             = runs_s2[0];
	assign remap_op        = op_s2;
	assign fill_color      = color_s2;
	assign last            = (rem_s2 == 3'd1);

endmodule

### rtl/planar_span_clip_fill_core.sv
// Top level of the planar span fill core: input register, span logic, run queue.
// Depends on pscf_pkg, pscf_cfg_regs, pscf_span_calc, pscf_run_queue and the macros header.
//
// A span request is taken at a clock edge where start is high and busy is low. When the run
// queue is idle or sending its final run, the span moves on from the input register into the
// run queue; otherwise it first waits in the input register while the earlier runs drain.
// Runs come out one per cycle with strobe high, and last marks the final run; a span that
// is rejected or clipped away produces no run at all. The receiver cannot stall, so each
// run is on the ports for exactly one cycle. A span gives one to three runs in fill mode
// and four in remap mode, and the run queue takes the next span while it sends the final
// run of the one before. Busy is high while a span waits in the input register for the run
// queue to reach its final run.
// Configuration writes take effect at once and must be made while no span is pending.
`include "planar_span_clip_fill_core_macros.svh"

module planar_span_clip_fill_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [7:0]                         color,
	input  logic signed [15:0]                 x,
	input  logic signed [15:0]                 y,
	input  logic signed [15:0]                 width,
	input  logic                               cfg_write,
	input  logic [pscf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pscf_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                               strobe,
	output logic [15:0]                        address,
	output logic [14:0]                        byte_count,
	output logic [3:0]                         plane_mask,
	output logic                               remap_op,
	output logic [7:0]                         fill_color,
	output logic                               last
);

	pscf_pkg::cfg_t            cfg;
	pscf_pkg::span_req_t       req_s1;
	pscf_pkg::run_set_t        runs;
	pscf_pkg::queue_status_t   status;
	pscf_pkg::run_t            run;
	logic                      valid_s1;
	logic                      accept;
	logic                      advance;

	pscf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign advance = valid_s1 && status.can_load;
	assign busy    = valid_s1 && !status.can_load;
	assign accept  = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.color <= color;
			req_s1.x     <= x;
			req_s1.y     <= y;
			req_s1.width <= width;
		end
	end

	pscf_span_calc u_calc (
		.req    (req_s1),
		.cfg    (cfg),
		.result (runs)
	);

	pscf_run_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (advance),
		.runs_in    (runs),
		.status     (status),
		.strobe     (strobe),
		.run        (run),
		.remap_op   (remap_op),
		.fill_color (fill_color),
		.last       (last)
	);

	assign address    = run.address;
	assign byte_count = run.byte_count;
	assign plane_mask = run.plane_mask;

	`PSCF_ASSERT_NEXT(a_runs_contiguous, strobe && !last, strobe)
	`PSCF_ASSERT_NEXT(a_remap_runs_stay_remap, strobe && remap_op && !last, strobe && remap_op)
	`PSCF_ASSERT_SAME(a_remap_single_plane, strobe && remap_op, $onehot(plane_mask))
	`PSCF_ASSERT_SAME(a_busy_only_when_queued, busy, strobe && !last)

endmodule
